### rtl/qvr_pkg.sv
// Shared types, widths and the 16.16 multiply for the quaternion vector rotator.
// Used by quaternion_vector_rotate, both checkers and the testbench top; depends on nothing else.
package qvr_pkg;

    localparam int FX_W      = 32;
    localparam int IN_FIELDS = 7;
    localparam int OUT_FIELDS = 3;
    localparam int IN_DW     = IN_FIELDS * FX_W;
    localparam int OUT_DW    = OUT_FIELDS * FX_W;

    typedef logic [FX_W-1:0] t_fx;
    typedef t_fx [2:0]       t_vec3;

    // Full signed product, keep bits 47..16 (floor shift by 16, then wrap).
    function automatic t_fx fx_mul(input t_fx a, input t_fx b);
        logic signed [2*FX_W-1:0] p;
        p = $signed(a) * $signed(b);
        return p[FX_W+15:16];
    endfunction

endpackage

### rtl/quaternion_vector_rotate.sv
// Each accepted input beat passes through the stage 1, 2, 3 and 4 registers to its output beat.
// Throughput: one beat per cycle while the output is not stalled; stage 1 forms the 13 dot and cross products, stage 2
// sums them into a, b and u x v and passes c on, stage 3 forms the 9 weighted products, stage 4 sums.
// A stage holds only when it is full and the one after it is full and stalled, so bubbles are filled.
// Reset (synchronous, active low) clears only the stage valid bits.
// Depends on qvr_pkg.
module quaternion_vector_rotate (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, 32 bits each from bit 0 up
    input  logic [qvr_pkg::IN_DW-1:0] i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // out_x, out_y, out_z, 32 bits each from bit 0 up
    output logic [qvr_pkg::OUT_DW-1:0] o_m_tdata
);
    import qvr_pkg::*;

    logic  rdy1, rdy2, rdy3, rdy4;
    t_fx   in_w;
    t_vec3 in_u, in_v;

    // Stage 1: products of the inputs.
    logic  r_s1_vld;
    t_vec3 r_s1_uv, r_s1_uu, r_s1_cpos, r_s1_cneg, r_s1_u, r_s1_v;
    t_fx   r_s1_ww, r_s1_c;
    t_vec3 n_s1_uv, n_s1_uu, n_s1_cpos, n_s1_cneg;

    // Stage 2: coefficients and the cross product.
    logic  r_s2_vld;
    t_fx   r_s2_a, r_s2_b, r_s2_c;
    t_vec3 r_s2_cr, r_s2_u, r_s2_v;
    t_fx   n_s2_a, n_s2_b;
    t_vec3 n_s2_cr;

    // Stage 3: weighted products.
    logic  r_s3_vld;
    t_vec3 r_s3_pa, r_s3_pb, r_s3_pc;
    t_vec3 n_s3_pa, n_s3_pb, n_s3_pc;

    // Stage 4: output register.
    logic  r_s4_vld;
    t_vec3 r_s4_out, n_s4_out;

    assign rdy4 = !r_s4_vld || i_m_tready;
    assign rdy3 = !r_s3_vld || rdy4;
    assign rdy2 = !r_s2_vld || rdy3;
    assign rdy1 = !r_s1_vld || rdy2;

    assign o_s_tready = rdy1;
    assign o_m_tvalid = r_s4_vld;
    assign o_m_tdata  = r_s4_out;

    assign in_w = i_s_tdata[FX_W-1:0];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_u[i] = i_s_tdata[(i+1)*FX_W +: FX_W];
            in_v[i] = i_s_tdata[(i+4)*FX_W +: FX_W];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_uv[i] = fx_mul(in_u[i], in_v[i]);
            n_s1_uu[i] = fx_mul(in_u[i], in_u[i]);
        end
        n_s1_cpos[0] = fx_mul(in_u[1], in_v[2]);
        n_s1_cneg[0] = fx_mul(in_u[2], in_v[1]);
        n_s1_cpos[1] = fx_mul(in_u[2], in_v[0]);
        n_s1_cneg[1] = fx_mul(in_u[0], in_v[2]);
        n_s1_cpos[2] = fx_mul(in_u[0], in_v[1]);
        n_s1_cneg[2] = fx_mul(in_u[1], in_v[0]);
    end

    always_comb begin
        n_s2_a = (r_s1_uv[0] + r_s1_uv[1] + r_s1_uv[2]) << 1;
        n_s2_b = r_s1_ww - (r_s1_uu[0] + r_s1_uu[1] + r_s1_uu[2]);
        for (int i = 0; i < 3; i++) begin
            n_s2_cr[i] = r_s1_cpos[i] - r_s1_cneg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s3_pa[i] = fx_mul(r_s2_a, r_s2_u[i]);
            n_s3_pb[i] = fx_mul(r_s2_b, r_s2_v[i]);
            n_s3_pc[i] = fx_mul(r_s2_c, r_s2_cr[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s4_out[i] = r_s3_pa[i] + r_s3_pb[i] + r_s3_pc[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (rdy1) r_s1_vld <= i_s_tvalid;
            if (rdy2) r_s2_vld <= r_s1_vld;
            if (rdy3) r_s3_vld <= r_s2_vld;
            if (rdy4) r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_uv   <= n_s1_uv;
            r_s1_uu   <= n_s1_uu;
            r_s1_cpos <= n_s1_cpos;
            r_s1_cneg <= n_s1_cneg;
            r_s1_ww   <= fx_mul(in_w, in_w);
            r_s1_c    <= in_w << 1;
            r_s1_u    <= in_u;
            r_s1_v    <= in_v;
        end
        if (rdy2) begin
            r_s2_a  <= n_s2_a;
            r_s2_b  <= n_s2_b;
            r_s2_c  <= r_s1_c;
            r_s2_cr <= n_s2_cr;
            r_s2_u  <= r_s1_u;
            r_s2_v  <= r_s1_v;
        end
        if (rdy3) begin
            r_s3_pa <= n_s3_pa;
            r_s3_pb <= n_s3_pb;
            r_s3_pc <= n_s3_pc;
        end
        if (rdy4) begin
            r_s4_out <= n_s4_out;
        end
    end

endmodule

### rtl/qvr_checker.sv
// Port-level checks for quaternion_vector_rotate, bound into that module below.
// Depends on qvr_pkg.
module qvr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic [qvr_pkg::IN_DW-1:0]  i_s_tdata,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [qvr_pkg::OUT_DW-1:0] o_m_tdata
);
    import qvr_pkg::*;

    logic in_acc;
    logic zero_quat;

    assign in_acc    = i_s_tvalid && o_s_tready;
    assign zero_quat = (i_s_tdata[4*FX_W-1:0] == '0);

    // An output beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output beat dropped while stalled");

    // Its data holds with it.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output data changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // With the output empty meanwhile, an accepted beat passes stages 1 to 4 without a hold and comes out.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_acc, 3) && !o_m_tvalid && $past(!o_m_tvalid) && $past(!o_m_tvalid, 2)
        |=> o_m_tvalid)
        else $error("beat missing at its expected latency");

    // A zero quaternion rotates any vector to zero.
    a_zero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_acc && zero_quat, 3) && !o_m_tvalid && $past(!o_m_tvalid)
        && $past(!o_m_tvalid, 2)
        |=> o_m_tdata == '0)
        else $error("zero quaternion gave a nonzero result");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

### tb/rotation_checker.sv
`timescale 1ns / 100ps
// Checker for quaternion_vector_rotate: watches both stream channels, predicts each rotated
// vector and compares it field by field with the output beats. Depends on qvr_pkg.
module rotation_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, 32 bits each from bit 0 up
    input  logic [qvr_pkg::IN_DW-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // out_x, out_y, out_z, 32 bits each from bit 0 up
    input  logic [qvr_pkg::OUT_DW-1:0] i_m_tdata,
    output int                        o_pending,
    output int                        o_errors
);
    import qvr_pkg::*;

    t_vec3 expected_rotations[$];
    int    pending_cnt = 0;
    int    error_cnt = 0;

    assign o_pending = pending_cnt;
    assign o_errors  = error_cnt;

    // Exact signed product, then floor shift by 16 and keep the low 32 bits.
    function automatic t_fx fx_product(input t_fx a, input t_fx b);
        longint sa;
        longint sb;
        longint full;
        sa   = longint'($signed(a));
        sb   = longint'($signed(b));
        full = sa * sb;
        return t_fx'(full >>> 16);
    endfunction

    function automatic t_vec3 rotate_by_quat(input t_fx w, input t_vec3 u, input t_vec3 v);
        t_fx   a;
        t_fx   b;
        t_fx   c;
        t_vec3 cr;
        t_vec3 r;
        a = (fx_product(u[0], v[0]) + fx_product(u[1], v[1]) + fx_product(u[2], v[2])) << 1;
        b = fx_product(w, w)
            - (fx_product(u[0], u[0]) + fx_product(u[1], u[1]) + fx_product(u[2], u[2]));
        c = w << 1;
        cr[0] = fx_product(u[1], v[2]) - fx_product(u[2], v[1]);
        cr[1] = fx_product(u[2], v[0]) - fx_product(u[0], v[2]);
        cr[2] = fx_product(u[0], v[1]) - fx_product(u[1], v[0]);
        for (int i = 0; i < 3; i++) begin
            r[i] = fx_product(a, u[i]) + fx_product(b, v[i]) + fx_product(c, cr[i]);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_fx got, input t_fx want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        error_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_fx   w;
        t_vec3 u;
        t_vec3 v;
        t_vec3 got;
        t_vec3 want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                w = i_s_tdata[FX_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    u[i] = i_s_tdata[FX_W*(1+i) +: FX_W];
                    v[i] = i_s_tdata[FX_W*(4+i) +: FX_W];
                end
                expected_rotations.push_back(rotate_by_quat(w, u, v));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_rotations.size() == 0) begin
                    report_mismatch("output beat with nothing pending, out_x", got[0], '0);
                end else begin
                    want = expected_rotations.pop_front();
                    if (got[0] !== want[0]) report_mismatch("out_x", got[0], want[0]);
                    if (got[1] !== want[1]) report_mismatch("out_y", got[1], want[1]);
                    if (got[2] !== want[2]) report_mismatch("out_z", got[2], want[2]);
                end
            end
            pending_cnt = expected_rotations.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the quaternion_vector_rotate testbench: clock, reset, stimulus and verdict.
// Depends on qvr_pkg, quaternion_vector_rotate and rotation_checker.
module tb_top;
    import qvr_pkg::*;

    localparam int  IDLE_LIMIT = 1000;
    localparam t_fx ONE = 32'h0001_0000;
    localparam t_fx MAXV = 32'h7FFF_FFFF;
    localparam t_fx MINV = 32'h8000_0000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_DW-1:0]  i_s_tdata;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_DW-1:0] o_m_tdata;

    int pending;
    int errors;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    quaternion_vector_rotate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    rotation_checker rot_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // A long stretch without any beat on either side means the block has hung.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_rotation(input t_fx w, input t_fx qx, input t_fx qy, input t_fx qz,
                                 input t_fx vx, input t_fx vy, input t_fx vz);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {vz, vy, vx, qz, qy, qx, w};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mix of full-range patterns, realistic magnitudes within +-4.0 and corner values.
    function automatic t_fx rand_fx();
        t_fx corners[6];
        corners = '{32'h0, MINV, MAXV, 32'hFFFF_FFFF, ONE, 32'hFFFF_0000};
        case ($urandom_range(9))
            0, 1, 2, 3: return t_fx'($urandom);
            4, 5, 6, 7: return t_fx'(int'($urandom_range(0, 32'h8_0000)) - 32'h4_0000);
            default:    return corners[$urandom_range(5)];
        endcase
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: identity, plain rotations, non-unit quaternions and wrapping extremes.
        send_rotation(0, 0, 0, 0, 0, 0, 0);
        send_rotation(ONE, 0, 0, 0, ONE, 2 * ONE, 3 * ONE);
        send_rotation(32'h0000_B505, 0, 0, 32'h0000_B505, ONE, 0, 0);
        send_rotation(0, ONE, 0, 0, 0, ONE, ONE);
        send_rotation(-ONE, 0, -ONE, 0, ONE, -ONE, ONE);
        send_rotation(MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        send_rotation(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_rotation('1, '1, '1, '1, '1, '1, '1);
        send_rotation(MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV);
        send_rotation(MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV);
        send_rotation(0, MAXV, MINV, MAXV, MINV, MAXV, MINV);
        send_rotation(2 * ONE, 3 * ONE, 32'hFFFE_8000, 32'h0000_8000,
                      -4 * ONE, 2 * ONE, 7 * ONE);
        send_rotation(32'h4000_0000, 0, 0, 32'h4000_0000, 32'h4000_0000, 0, 0);
        send_rotation(MAXV, 0, 0, 0, MAXV, MINV, 1);
        send_rotation(1, 1, 1, 1, 1, 1, 1);
        send_rotation(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_rotation(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_rotation(MINV, MINV, 0, 0, 0, MINV, 0);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            for (int n = 0; n < 135; n++) begin
                send_rotation(rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                              rand_fx(), rand_fx(), rand_fx());
            end
            wait_for_results();
        end

        // Give a spurious extra beat the chance to show up.
        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate.sv
rtl/qvr_checker.sv
tb/rotation_checker.sv
tb/tb_top.sv
